@@ sv/calendar_date_counter_assert.svh @@
// assertion macros for the calendar date counter
// expects clk and rst_n in the scope of each use
`ifndef CALENDAR_DATE_COUNTER_ASSERT_SVH
`define CALENDAR_DATE_COUNTER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CDC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define CDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cdc_pkg.sv @@
// shared types, constants and month length function for the date counter
// no dependencies
package cdc_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_INC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_CMP  = 2'd3
    } cmd_t;

    // year limits and default date
    localparam logic [13:0] YEAR_MIN     = 14'd1000;
    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [13:0] YEAR_DEFAULT = 14'd2000;
    localparam logic [3:0]  MONTH_FIRST  = 4'd1;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [3:0]  MONTH_LIMIT  = 4'd13;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;

    // month lengths
    localparam logic [4:0] FEB_DAYS      = 5'd28;
    localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
    localparam logic [4:0] SHORT_DAYS    = 5'd30;
    localparam logic [4:0] LONG_DAYS     = 5'd31;

    // divisibility by 25 through a scaled reciprocal, exact for 14 bit years
    localparam int          DIV25_SHIFT = 19;
    localparam logic [14:0] DIV25_MUL   = 15'd20972;

    // input item
    typedef struct packed {
        cmd_t        command;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [13:0] year_in;
    } in_t;

    // result item
    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic        is_less;
        logic        is_equal;
        logic        corrected;
        logic        wrapped;
    } out_t;

    // stored date
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_t;

    // days in a month; a month outside 1..12 counts as a long month
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                   d = leap ? FEB_LEAP_DAYS : FEB_DAYS;
            4'd4, 4'd6, 4'd9, 4'd11: d = SHORT_DAYS;
            default:                d = LONG_DAYS;
        endcase
        return d;
    endfunction

endpackage

@@ sv/calendar_date_counter.sv @@
// Gregorian date counter top level: input register, date register, result register
// uses cdc_pkg, cdc_next and calendar_date_counter_assert.svh
//
// Usage: commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd_item)
// and one result item per command leaves on the date channel (date_valid,
// date_stall, date_item). A command item is taken at a clock edge with
// cmd_valid high and cmd_stall low; a result is taken likewise on the date side.
// Result path: input register, then result register when no stalled result waits.
// Throughput: one command per clock unless stalled; the stored date is updated
// in the same cycle that the result register loads, so commands may follow back
// to back. The date register, updated through one pass of the step logic,
// sets this. Reset: the stored date becomes 01/01/2000 and both item registers
// empty. Stall: while date_stall holds a waiting result, one more command is
// still taken into the input register; cmd_stall then rises until the result
// drains.
`include "calendar_date_counter_assert.svh"

module calendar_date_counter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  cdc_pkg::in_t  cmd_item,
    output logic          date_valid,
    input  logic          date_stall,
    output cdc_pkg::out_t date_item
);

    logic           in_valid_reg;
    logic           in_valid_next;
    cdc_pkg::in_t   in_item_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    cdc_pkg::out_t  out_item_reg;
    cdc_pkg::date_t date_reg;
    cdc_pkg::date_t date_next;
    cdc_pkg::out_t  result;
    logic           advance;

    // step logic
    cdc_next u_next (
        .item   (in_item_reg),
        .cur    (date_reg),
        .nxt    (date_next),
        .result (result)
    );

    // handshake control
    assign advance       = in_valid_reg && (!out_valid_reg || !date_stall);
    assign cmd_stall     = in_valid_reg && !advance;
    assign in_valid_next = cmd_stall ? in_valid_reg : cmd_valid;
    assign out_valid_next = advance ? 1'b1 : (date_stall ? out_valid_reg : 1'b0);

    // valid flags and stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            date_reg.day   <= cdc_pkg::DAY_FIRST;
            date_reg.month <= cdc_pkg::MONTH_FIRST;
            date_reg.year  <= cdc_pkg::YEAR_DEFAULT;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                date_reg <= date_next;
            end
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            in_item_reg <= cmd_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign date_valid = out_valid_reg;
    assign date_item  = out_item_reg;

    // checks
    `CDC_ASSERT_IMPLIES(a_out_matches_date, out_valid_reg, (out_item_reg.day_out == date_reg.day) && (out_item_reg.month_out == date_reg.month) && (out_item_reg.year_out == date_reg.year), "result date differs from stored date")
    `CDC_ASSERT_IMPLIES(a_wrap_default, out_valid_reg && out_item_reg.wrapped, (date_reg.day == cdc_pkg::DAY_FIRST) && (date_reg.month == cdc_pkg::MONTH_FIRST) && (date_reg.year == cdc_pkg::YEAR_DEFAULT), "wrap without default date")
    `CDC_ASSERT_IMPLIES(a_stall_cause, cmd_stall, out_valid_reg && date_stall && in_valid_reg, "input stalled without back pressure")
    `CDC_ASSERT_ALWAYS(a_flags_exclusive, $countones({out_item_reg.is_less, out_item_reg.is_equal, out_item_reg.corrected, out_item_reg.wrapped}) <= 1 || !out_valid_reg, "more than one result flag set")

endmodule

@@ sv/cdc_leap.sv @@
// leap year detector for a 14 bit year
// uses cdc_pkg for the reciprocal constants
module cdc_leap (
    input  logic [13:0] year,
    output logic        leap
);

    localparam int PROD_W = 29;

    logic [PROD_W-1:0] prod;
    logic              div4;
    logic              div16;
    logic              div25;

    // fractional part of year/25 is near zero exactly when 25 divides year
    assign prod  = PROD_W'(year) * PROD_W'(cdc_pkg::DIV25_MUL);
    assign div25 = prod[cdc_pkg::DIV25_SHIFT-1:0]
                   < cdc_pkg::DIV25_SHIFT'(cdc_pkg::DIV25_MUL);
    assign div4  = (year[1:0] == 2'd0);
    assign div16 = (year[3:0] == 4'd0);

    // divisible by 4, and not by 100 unless by 400
    assign leap = div4 && (!div25 || div16);

endmodule

@@ sv/cdc_next.sv @@
// next date and result flags for one command
// uses cdc_pkg and cdc_leap
module cdc_next (
    input  cdc_pkg::in_t   item,
    input  cdc_pkg::date_t cur,
    output cdc_pkg::date_t nxt,
    output cdc_pkg::out_t  result
);

    logic        cur_leap;
    logic        in_leap;
    logic        year_ok;
    logic        month_ok;
    logic        day_ok;
    logic        load_leap;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  cur_len;
    logic [4:0]  prev_len;
    logic        is_less;
    logic        is_equal;

    cdc_leap u_cur_leap (
        .year (cur.year),
        .leap (cur_leap)
    );

    cdc_leap u_in_leap (
        .year (item.year_in),
        .leap (in_leap)
    );

    // load validation
    assign year_ok    = (item.year_in >= cdc_pkg::YEAR_MIN) && (item.year_in <= cdc_pkg::YEAR_MAX);
    assign month_ok   = (item.month_in >= cdc_pkg::MONTH_FIRST)
                        && (item.month_in < cdc_pkg::MONTH_LIMIT);
    assign load_year  = year_ok ? item.year_in : cdc_pkg::YEAR_DEFAULT;
    assign load_month = month_ok ? item.month_in : cdc_pkg::MONTH_FIRST;
    // the default year is a leap year
    assign load_leap  = year_ok ? in_leap : 1'b1;
    assign day_ok     = (item.day_in >= cdc_pkg::DAY_FIRST)
                        && (item.day_in <= cdc_pkg::days_in(load_month, load_leap));

    // month lengths for stepping
    assign cur_len  = cdc_pkg::days_in(cur.month, cur_leap);
    assign prev_len = cdc_pkg::days_in(cur.month - 4'd1, cur_leap);

    // raw lexicographic compare, year then month then day
    assign is_less  = {cur.year, cur.month, cur.day}
                      < {item.year_in, item.month_in, item.day_in};
    assign is_equal = {cur.year, cur.month, cur.day}
                      == {item.year_in, item.month_in, item.day_in};

    // command decode
    always_comb
    begin
        nxt              = cur;
        result.is_less   = 1'b0;
        result.is_equal  = 1'b0;
        result.corrected = 1'b0;
        result.wrapped   = 1'b0;
        case (item.command)
            cdc_pkg::CMD_LOAD:
            begin
                nxt.year         = load_year;
                nxt.month        = load_month;
                nxt.day          = day_ok ? item.day_in : cdc_pkg::DAY_FIRST;
                result.corrected = !(year_ok && month_ok && day_ok);
            end
            cdc_pkg::CMD_INC:
            begin
                if (cur.day >= cur_len)
                begin
                    nxt.day = cdc_pkg::DAY_FIRST;
                    if (cur.month >= cdc_pkg::MONTH_LAST)
                    begin
                        nxt.month = cdc_pkg::MONTH_FIRST;
                        if (cur.year >= cdc_pkg::YEAR_MAX)
                        begin
                            nxt.year       = cdc_pkg::YEAR_DEFAULT;
                            result.wrapped = 1'b1;
                        end
                        else
                        begin
                            nxt.year = cur.year + 14'd1;
                        end
                    end
                    else
                    begin
                        nxt.month = cur.month + 4'd1;
                    end
                end
                else
                begin
                    nxt.day = cur.day + 5'd1;
                end
            end
            cdc_pkg::CMD_DEC:
            begin
                if (cur.day <= cdc_pkg::DAY_FIRST)
                begin
                    if (cur.month <= cdc_pkg::MONTH_FIRST)
                    begin
                        if (cur.year <= cdc_pkg::YEAR_MIN)
                        begin
                            nxt.year       = cdc_pkg::YEAR_DEFAULT;
                            nxt.month      = cdc_pkg::MONTH_FIRST;
                            nxt.day        = cdc_pkg::DAY_FIRST;
                            result.wrapped = 1'b1;
                        end
                        else
                        begin
                            // december is always a long month
                            nxt.year  = cur.year - 14'd1;
                            nxt.month = cdc_pkg::MONTH_LAST;
                            nxt.day   = cdc_pkg::LONG_DAYS;
                        end
                    end
                    else
                    begin
                        nxt.month = cur.month - 4'd1;
                        nxt.day   = prev_len;
                    end
                end
                else
                begin
                    nxt.day = cur.day - 5'd1;
                end
            end
            cdc_pkg::CMD_CMP:
            begin
                result.is_less  = is_less;
                result.is_equal = is_equal;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        result.day_out   = nxt.day;
        result.month_out = nxt.month;
        result.year_out  = nxt.year;
    end

endmodule
